/* hw/rtl/st2d_pkg.sv */
// shared types, codes and helpers for the 2d sparse table range query block
// depends on nothing; used by the front end, the back end and the top module
package st2d_pkg;

    localparam int DEF_MAX_ROWS   = 32;
    localparam int DEF_MAX_COLS   = 32;
    localparam int DEF_DATA_WIDTH = 32;

    // configuration register indexes
    localparam logic [1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [1:0] REG_COL_COUNT = 2'd1;
    localparam logic [1:0] REG_OP_MODE   = 2'd2;

    // reset values of the registers
    localparam logic [5:0] ROW_COUNT_RST = 6'd32;
    localparam logic [5:0] COL_COUNT_RST = 6'd32;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_MIN = 2'd0,
        OP_MAX = 2'd1,
        OP_AND = 2'd2,
        OP_OR  = 2'd3
    } op_t;

    // work kinds handed from front to back
    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_BUILD = 2'd1,
        K_QUERY = 2'd2,
        K_ERROR = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_BRA,
        BK_BRB,
        BK_BWR,
        BK_Q0,
        BK_Q1,
        BK_Q2,
        BK_Q3,
        BK_QD
    } bk_state_t;

    // one classified word, sized for the largest configuration
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  status;
        logic [3:0]  kx;
        logic [3:0]  ky;
        logic [7:0]  r1;
        logic [7:0]  c1;
        logic [7:0]  r3;
        logic [7:0]  c3;
        logic [63:0] data;
    } item_t;

    // idempotent combine, at the widest data width
    function automatic logic [63:0] combine(input logic [63:0] a, input logic [63:0] b,
                                            input op_t op);
        logic [63:0] r;
        case (op)
            OP_MIN:  r = (a < b) ? a : b;
            OP_MAX:  r = (a > b) ? a : b;
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            default: r = a | b;
        endcase
        return r;
    endfunction

    // count in use: zero taken as one, clamped to the maximum
    function automatic logic [9:0] count_in_use(input logic [5:0] cnt, input int maxv);
        logic [9:0] r;
        r = {4'd0, cnt};
        if (r == 10'd0) r = 10'd1;
        if (r > 10'(maxv)) r = 10'(maxv);
        return r;
    endfunction

endpackage

/* hw/rtl/st2d_ram.sv */
// generic single write, single read ram with registered read data
// depends on nothing
module st2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* hw/rtl/st2d_front.sv */
// front end: accepts input words, classifies them and queues them for the back end
// depends on st2d_pkg
module st2d_front #(
    parameter int MAX_ROWS   = st2d_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = st2d_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = st2d_pkg::DEF_DATA_WIDTH,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          cmd,
    input  logic [4:0]          row_a,
    input  logic [4:0]          col_a,
    input  logic [4:0]          row_b,
    input  logic [4:0]          col_b,
    input  logic [31:0]         cell_value,
    input  logic [RW:0]         n_use,
    input  logic [CW:0]         m_use,
    input  logic                cfg_hit,
    output logic                q_valid,
    output st2d_pkg::item_t     q_item,
    input  logic                q_pop
);

    st2d_pkg::item_t q_mem_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            built_reg;

    st2d_pkg::item_t item;
    logic            enq, accept;
    logic [9:0]      ra, rb, ca, cb, n10, m10, x1, x2, y1, y2, lx, ly, x3, y3;
    logic [3:0]      kx, ky;
    logic            in_rng;

    assign full    = (count_reg == 2'd2);
    assign accept  = push && !full;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    // corner ordering, range check and level choice
    always_comb
    begin
        ra  = {5'd0, row_a};
        rb  = {5'd0, row_b};
        ca  = {5'd0, col_a};
        cb  = {5'd0, col_b};
        n10 = 10'(n_use);
        m10 = 10'(m_use);
        in_rng = (ra < n10) && (rb < n10) && (ca < m10) && (cb < m10);
        x1 = (ra < rb) ? ra : rb;
        x2 = (ra < rb) ? rb : ra;
        y1 = (ca < cb) ? ca : cb;
        y2 = (ca < cb) ? cb : ca;
        lx = x2 - x1 + 10'd1;
        ly = y2 - y1 + 10'd1;
        kx = 4'd0;
        ky = 4'd0;
        for (int k = 0; k < 9; k++)
        begin
            if (lx[k]) kx = 4'(k);
            if (ly[k]) ky = 4'(k);
        end
        x3 = x2 + 10'd1 - (10'd1 << kx);
        y3 = y2 + 10'd1 - (10'd1 << ky);
    end

    // build the queued word
    always_comb
    begin
        item        = '0;
        item.kx     = kx;
        item.ky     = ky;
        item.r1     = 8'(x1);
        item.c1     = 8'(y1);
        item.r3     = 8'(x3);
        item.c3     = 8'(y3);
        item.data   = 64'(DATA_WIDTH'(cell_value));
        item.status = st2d_pkg::ST_OK;
        enq         = 1'b0;
        case (st2d_pkg::cmd_t'(cmd))
            st2d_pkg::CMD_LOAD:
            begin
                item.kind = st2d_pkg::K_LOAD;
                item.r1   = 8'(ra);
                item.c1   = 8'(ca);
                enq       = (ra < n10) && (ca < m10);
            end
            st2d_pkg::CMD_BUILD:
            begin
                item.kind = st2d_pkg::K_BUILD;
                enq       = 1'b1;
            end
            st2d_pkg::CMD_QUERY:
            begin
                enq = 1'b1;
                if (!built_reg)
                begin
                    item.kind   = st2d_pkg::K_ERROR;
                    item.status = st2d_pkg::ST_NOT_BUILT;
                end
                else if (!in_rng)
                begin
                    item.kind   = st2d_pkg::K_ERROR;
                    item.status = st2d_pkg::ST_RANGE;
                end
                else
                begin
                    item.kind = st2d_pkg::K_QUERY;
                end
            end
            default:
            begin
                item.kind = st2d_pkg::K_ERROR;
                enq       = 1'b0;
            end
        endcase
    end

    // table built flag, tracked in accept order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            built_reg <= 1'b0;
        end
        else if (cfg_hit)
        begin
            built_reg <= 1'b0;
        end
        else if (accept && cmd == st2d_pkg::CMD_LOAD)
        begin
            built_reg <= 1'b0;
        end
        else if (accept && cmd == st2d_pkg::CMD_BUILD)
        begin
            built_reg <= 1'b1;
        end
    end

    // two entry queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept && enq) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)         rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(accept && enq) - 2'(q_pop);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept && enq)
        begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("queue popped while empty");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count overflow");
    a_build_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == st2d_pkg::CMD_BUILD && !cfg_hit) |=> built_reg)
        else $error("built flag not set after build");

endmodule

/* hw/rtl/st2d_back.sv */
// back end: runs loads, the table build sweep and four read queries on the level ram
// depends on st2d_pkg and st2d_ram
module st2d_back #(
    parameter int MAX_ROWS   = st2d_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = st2d_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = st2d_pkg::DEF_DATA_WIDTH,
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int KXW = $clog2(RW + 2),
    localparam int KYW = $clog2(CW + 2),
    localparam int AW  = KXW + KYW + RW + CW
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [RW:0]     n_use,
    input  logic [CW:0]     m_use,
    input  st2d_pkg::op_t   op_mode,
    input  logic            q_valid,
    input  st2d_pkg::item_t q_item,
    output logic            q_pop,
    output logic            empty,
    input  logic            pop,
    output logic [31:0]     result_value,
    output logic [1:0]      status
);

    st2d_pkg::bk_state_t state_reg, state_next;
    st2d_pkg::item_t     cur_reg;
    logic [KXW-1:0]      bkx_reg;
    logic [KYW-1:0]      bky_reg;
    logic [RW-1:0]       bi_reg;
    logic [CW-1:0]       bj_reg;
    logic [DATA_WIDTH-1:0] a_reg, acc_reg;

    logic [33:0] res_mem_reg [2];
    logic        rwp_reg, rrp_reg;
    logic [1:0]  rcnt_reg;
    logic        room, res_push;
    logic [33:0] res_word;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata, comb_a, comb_acc;

    logic [RW+1:0] n_x, ext_i, sh_x, sh_xn;
    logic [CW+1:0] m_x, ext_j, sh_y, sh_yn;
    logic          last_j, last_i, ky_more, kx_more, start_ok, take;

    assign room = (rcnt_reg != 2'd2);
    assign take = q_valid && (state_reg == st2d_pkg::BK_IDLE) &&
                  (room || q_item.kind == st2d_pkg::K_LOAD ||
                   q_item.kind == st2d_pkg::K_BUILD);

    st2d_ram #(.WIDTH(DATA_WIDTH), .DEPTH(2 ** AW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign comb_a   = DATA_WIDTH'(st2d_pkg::combine(64'(a_reg), 64'(rdata), op_mode));
    assign comb_acc = DATA_WIDTH'(st2d_pkg::combine(64'(acc_reg), 64'(rdata), op_mode));

    // sweep bounds of the current level
    always_comb
    begin
        n_x     = (RW + 2)'(n_use);
        m_x     = (CW + 2)'(m_use);
        sh_x    = (RW + 2)'(1) << bkx_reg;
        sh_y    = (CW + 2)'(1) << bky_reg;
        sh_xn   = (RW + 2)'(1) << (bkx_reg + KXW'(1));
        sh_yn   = (CW + 2)'(1) << (bky_reg + KYW'(1));
        ext_i   = (RW + 2)'(bi_reg) + sh_x;
        ext_j   = (CW + 2)'(bj_reg) + sh_y;
        last_i  = (ext_i == n_x);
        last_j  = (ext_j == m_x);
        ky_more = (sh_yn <= m_x);
        kx_more = (sh_xn <= n_x);
        start_ok = (n_x >= (RW + 2)'(2)) || (m_x >= (CW + 2)'(2));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            st2d_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    case (q_item.kind)
                        st2d_pkg::K_BUILD: if (start_ok) state_next = st2d_pkg::BK_BRA;
                        st2d_pkg::K_QUERY: state_next = st2d_pkg::BK_Q0;
                        default:           state_next = st2d_pkg::BK_IDLE;
                    endcase
                end
            end
            st2d_pkg::BK_BRA: state_next = st2d_pkg::BK_BRB;
            st2d_pkg::BK_BRB: state_next = st2d_pkg::BK_BWR;
            st2d_pkg::BK_BWR:
            begin
                if (last_j && last_i && !ky_more && !kx_more)
                    state_next = st2d_pkg::BK_IDLE;
                else
                    state_next = st2d_pkg::BK_BRA;
            end
            st2d_pkg::BK_Q0: state_next = st2d_pkg::BK_Q1;
            st2d_pkg::BK_Q1: state_next = st2d_pkg::BK_Q2;
            st2d_pkg::BK_Q2: state_next = st2d_pkg::BK_Q3;
            st2d_pkg::BK_Q3: state_next = st2d_pkg::BK_QD;
            st2d_pkg::BK_QD: state_next = st2d_pkg::BK_IDLE;
            default:         state_next = st2d_pkg::BK_IDLE;
        endcase
    end

    // ram ports and result push
    always_comb
    begin
        we       = 1'b0;
        waddr    = {bkx_reg, bky_reg, bi_reg, bj_reg};
        wdata    = comb_a;
        raddr    = {KXW'(cur_reg.kx), KYW'(cur_reg.ky), RW'(cur_reg.r1), CW'(cur_reg.c1)};
        res_push = 1'b0;
        res_word = {st2d_pkg::ST_OK, 32'(comb_acc)};
        q_pop    = take;
        case (state_reg)
            st2d_pkg::BK_IDLE:
            begin
                if (take && q_item.kind == st2d_pkg::K_LOAD)
                begin
                    we    = 1'b1;
                    waddr = {KXW'(0), KYW'(0), RW'(q_item.r1), CW'(q_item.c1)};
                    wdata = DATA_WIDTH'(q_item.data);
                end
                if (take && q_item.kind == st2d_pkg::K_ERROR)
                begin
                    res_push = 1'b1;
                    res_word = {q_item.status, 32'd0};
                end
            end
            st2d_pkg::BK_BRA:
            begin
                if (bkx_reg == KXW'(0))
                    raddr = {bkx_reg, bky_reg - KYW'(1), bi_reg, bj_reg};
                else
                    raddr = {bkx_reg - KXW'(1), bky_reg, bi_reg, bj_reg};
            end
            st2d_pkg::BK_BRB:
            begin
                if (bkx_reg == KXW'(0))
                    raddr = {bkx_reg, bky_reg - KYW'(1), bi_reg,
                             bj_reg + CW'(sh_y >> 1)};
                else
                    raddr = {bkx_reg - KXW'(1), bky_reg,
                             bi_reg + RW'(sh_x >> 1), bj_reg};
            end
            st2d_pkg::BK_BWR: we = 1'b1;
            st2d_pkg::BK_Q1:
                raddr = {KXW'(cur_reg.kx), KYW'(cur_reg.ky), RW'(cur_reg.r3), CW'(cur_reg.c1)};
            st2d_pkg::BK_Q2:
                raddr = {KXW'(cur_reg.kx), KYW'(cur_reg.ky), RW'(cur_reg.r1), CW'(cur_reg.c3)};
            st2d_pkg::BK_Q3:
                raddr = {KXW'(cur_reg.kx), KYW'(cur_reg.ky), RW'(cur_reg.r3), CW'(cur_reg.c3)};
            st2d_pkg::BK_QD: res_push = 1'b1;
            default: ;
        endcase
    end

    // state and sweep counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= st2d_pkg::BK_IDLE;
            bkx_reg   <= '0;
            bky_reg   <= '0;
            bi_reg    <= '0;
            bj_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == st2d_pkg::BK_IDLE)
            begin
                bi_reg <= '0;
                bj_reg <= '0;
                if (m_x >= (CW + 2)'(2))
                begin
                    bkx_reg <= '0;
                    bky_reg <= KYW'(1);
                end
                else
                begin
                    bkx_reg <= KXW'(1);
                    bky_reg <= '0;
                end
            end
            else if (state_reg == st2d_pkg::BK_BWR)
            begin
                if (!last_j)
                    bj_reg <= bj_reg + CW'(1);
                else
                begin
                    bj_reg <= '0;
                    if (!last_i)
                        bi_reg <= bi_reg + RW'(1);
                    else
                    begin
                        bi_reg <= '0;
                        if (ky_more)
                            bky_reg <= bky_reg + KYW'(1);
                        else
                        begin
                            bky_reg <= '0;
                            bkx_reg <= bkx_reg + KXW'(1);
                        end
                    end
                end
            end
        end
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        if (take) cur_reg <= q_item;
        if (state_reg == st2d_pkg::BK_BRB) a_reg <= rdata;
        if (state_reg == st2d_pkg::BK_Q1)
            acc_reg <= rdata;
        else if (state_reg == st2d_pkg::BK_Q2 || state_reg == st2d_pkg::BK_Q3)
            acc_reg <= comb_acc;
    end

    // result queue
    assign empty        = (rcnt_reg == 2'd0);
    assign result_value = res_mem_reg[rrp_reg][31:0];
    assign status       = res_mem_reg[rrp_reg][33:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rwp_reg  <= 1'b0;
            rrp_reg  <= 1'b0;
            rcnt_reg <= 2'd0;
        end
        else
        begin
            if (res_push)       rwp_reg <= ~rwp_reg;
            if (pop && !empty)  rrp_reg <= ~rrp_reg;
            rcnt_reg <= rcnt_reg + 2'(res_push) - 2'(pop && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push) res_mem_reg[rwp_reg] <= res_word;
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> room || (pop && !empty)) else $error("result queue overflow");
    a_query_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == st2d_pkg::BK_IDLE && state_next == st2d_pkg::BK_Q0) |-> room)
        else $error("query started without result space");
    a_sweep_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == st2d_pkg::BK_BWR) |-> ext_i <= n_x && ext_j <= m_x)
        else $error("build sweep left the level");
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> state_reg == st2d_pkg::BK_BWR || state_reg == st2d_pkg::BK_IDLE)
        else $error("ram write outside load or build");

endmodule

/* hw/rtl/sparse_table_2d_range_query.sv */
// 2d sparse table range query block: the back end reads a query's four corners in states
// q0 to q3 and pushes its result in qd, an error result as its word is taken, and it takes
// no new word before it is back in idle. a load is written as its word is taken; a build
// sweeps all levels, as every entry needs two reads and a write through the single ram.
// reset clears the registers to 32 rows, 32 columns, min operator, and marks the table unbuilt;
// the table ram is not cleared and holds nothing valid until built.
module sparse_table_2d_range_query #(
    parameter int MAX_ROWS   = st2d_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = st2d_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = st2d_pkg::DEF_DATA_WIDTH,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic [4:0]  row_a,
    input  logic [4:0]  col_a,
    input  logic [4:0]  row_b,
    input  logic [4:0]  col_b,
    input  logic [31:0] cell_value,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] result_value,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    logic [5:0]      row_count_reg, col_count_reg;
    st2d_pkg::op_t   op_mode_reg;
    logic            cfg_hit, q_valid, q_pop;
    st2d_pkg::item_t q_item;
    logic [RW:0]     n_use;
    logic [CW:0]     m_use;

    assign cfg_hit = cfg_we && (cfg_index == st2d_pkg::REG_ROW_COUNT ||
                                cfg_index == st2d_pkg::REG_COL_COUNT ||
                                cfg_index == st2d_pkg::REG_OP_MODE);
    assign n_use   = (RW + 1)'(st2d_pkg::count_in_use(row_count_reg, MAX_ROWS));
    assign m_use   = (CW + 1)'(st2d_pkg::count_in_use(col_count_reg, MAX_COLS));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= st2d_pkg::ROW_COUNT_RST;
            col_count_reg <= st2d_pkg::COL_COUNT_RST;
            op_mode_reg   <= st2d_pkg::OP_MIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                st2d_pkg::REG_ROW_COUNT: row_count_reg <= cfg_data;
                st2d_pkg::REG_COL_COUNT: col_count_reg <= cfg_data;
                st2d_pkg::REG_OP_MODE:   op_mode_reg   <= st2d_pkg::op_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    st2d_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .row_a      (row_a),
        .col_a      (col_a),
        .row_b      (row_b),
        .col_b      (col_b),
        .cell_value (cell_value),
        .n_use      (n_use),
        .m_use      (m_use),
        .cfg_hit    (cfg_hit),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    st2d_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .n_use        (n_use),
        .m_use        (m_use),
        .op_mode      (op_mode_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .result_value (result_value),
        .status       (status)
    );

    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> row_count_reg == $past(cfg_index == st2d_pkg::REG_ROW_COUNT ?
                                           cfg_data : row_count_reg))
        else $error("row count write lost");

endmodule
